// ===== rtl/core/unicode_keystroke_sequencer_macros.svh =====
// Assertion macros shared by the keystroke sequencer RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef UNICODE_KEYSTROKE_SEQUENCER_MACROS_SVH
`define UNICODE_KEYSTROKE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define UKS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keystroke sequencer check failed");

// Antecedent implies consequent in the next cycle.
`define UKS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keystroke sequencer check failed");

`else

`define UKS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UKS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/uks_pkg.sv =====
// Package for the Unicode keystroke sequencer: payload structs, codes,
// HID constants and the hex digit to usage lookup. No dependencies.
`timescale 1ns / 1ps

package uks_pkg;

	typedef enum logic [1:0] {
		MODE_LINUX   = 2'd0,
		MODE_MACOS   = 2'd1,
		MODE_WINDOWS = 2'd2,
		MODE_NONE    = 2'd3
	} host_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE_DOWN,
		ST_PRE_UP,
		ST_DIG_DOWN,
		ST_DIG_UP,
		ST_POST_DOWN,
		ST_POST_UP,
		ST_FINAL
	} seq_state_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        text_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] key_code;
		logic       run_last;
		logic       bad_mode;
		logic       text_done;
	} out_item_t;

	// Control from the sequencer to the digit shifter.
	typedef struct packed {
		logic load;
		logic shift;
	} shift_ctrl_t;

	localparam int unsigned MaxDigits = 8;
	localparam int unsigned DigitBits = 4 * MaxDigits;
	localparam int unsigned CountW    = $clog2(MaxDigits + 1);

	localparam logic [7:0] MOD_EMPTY = 8'h00;
	localparam logic [7:0] MOD_CTRL  = 8'h01;
	localparam logic [7:0] MOD_SHIFT = 8'h02;
	localparam logic [7:0] MOD_ALT   = 8'h04;

	localparam logic [7:0] KEY_NONE    = 8'h00;
	localparam logic [7:0] KEY_U       = 8'h18;
	localparam logic [7:0] KEY_SPACE   = 8'h2C;
	localparam logic [7:0] KEY_KP_PLUS = 8'h57;

	localparam logic [20:0] SURR_OFFSET = 21'h10000;
	localparam logic [15:0] SURR_HIGH   = 16'hD800;
	localparam logic [15:0] SURR_LOW    = 16'hDC00;

	function automatic logic [7:0] digit_key(input logic [3:0] d);
		logic [7:0] k;
		case (d)
			4'h0: k = 8'h27;
			4'h1: k = 8'h1E;
			4'h2: k = 8'h1F;
			4'h3: k = 8'h20;
			4'h4: k = 8'h21;
			4'h5: k = 8'h22;
			4'h6: k = 8'h23;
			4'h7: k = 8'h24;
			4'h8: k = 8'h25;
			4'h9: k = 8'h26;
			4'hA: k = 8'h04;
			4'hB: k = 8'h05;
			4'hC: k = 8'h06;
			4'hD: k = 8'h07;
			4'hE: k = 8'h08;
			4'hF: k = 8'h09;
			default: k = 8'h27;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/core/unicode_keystroke_sequencer.sv =====
// Top level of the Unicode keystroke sequencer: report sequencer, output
// register and mode register. Depends on uks_pkg, uks_digit_shifter, macros.
//
//   channel   direction  handshake           payload
//   in        to block   in_valid/in_stall   uks_pkg::in_item_t
//   out       from block out_valid/out_stall uks_pkg::out_item_t
//   cfg       to block   cfg_we              cfg_data (host mode)
//
// One report leaves the sequencer per cycle while the output register can take it.
// How many reports an item takes depends on the host mode and on the digits to send;
// the serial digit shifter steps through those digits.
// The next item is taken once the final report of the previous one is in the
// output register. Output stalls hold the sequencer in place.
// Reset sets the mode to Linux and empties the sequencer and output register.
`timescale 1ns / 1ps
`include "unicode_keystroke_sequencer_macros.svh"

module unicode_keystroke_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  uks_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output uks_pkg::out_item_t out_item
);

	uks_pkg::host_mode_t  host_mode_q;
	uks_pkg::seq_state_t  state_q, state_nxt, first_state;
	logic                 end_q;
	logic                 out_valid_q;
	uks_pkg::out_item_t   out_q, report;
	logic                 accept, adv;

	uks_pkg::shift_ctrl_t             sh_ctrl;
	logic [uks_pkg::DigitBits-1:0]    load_digits, hex_aligned, hex_ext;
	logic [uks_pkg::CountW-1:0]       load_count, hex_count;
	logic [7:0]                       dig_key;
	logic                             last_digit;
	logic [5:0]                       nib_nz;
	logic [20:0]                      surr_v;
	logic [15:0]                      surr_hi, surr_lo;
	logic [uks_pkg::CountW-1:0]       shift_nibs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_mode_q <= uks_pkg::MODE_LINUX;
		end else if (cfg_we) begin
			host_mode_q <= uks_pkg::host_mode_t'(cfg_data);
		end
	end

	assign in_stall = (state_q != uks_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign adv      = (state_q != uks_pkg::ST_IDLE) && (!out_valid_q || !out_stall);

	// Digit count without leading zeros, at least one digit.
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			nib_nz[i] = |in_item.code_point[4*i +: 4];
		end
		nib_nz[5] = in_item.code_point[20];
		hex_count = uks_pkg::CountW'(1);
		for (int i = 1; i < 6; i++) begin
			if (nib_nz[i]) begin
				hex_count = uks_pkg::CountW'(i + 1);
			end
		end
	end

	assign shift_nibs  = uks_pkg::CountW'(uks_pkg::MaxDigits) - hex_count;
	assign hex_ext     = {{(uks_pkg::DigitBits-21){1'b0}}, in_item.code_point};
	assign hex_aligned = hex_ext << {shift_nibs, 2'b00};

	// UTF-16 surrogate pair for code points above the basic plane.
	assign surr_v  = in_item.code_point - uks_pkg::SURR_OFFSET;
	assign surr_hi = uks_pkg::SURR_HIGH + {5'd0, surr_v[20:10]};
	assign surr_lo = uks_pkg::SURR_LOW + {6'd0, surr_v[9:0]};

	always_comb begin
		if (host_mode_q == uks_pkg::MODE_MACOS) begin
			if (|in_item.code_point[20:16]) begin
				load_digits = {surr_hi, surr_lo};
				load_count  = uks_pkg::CountW'(8);
			end else begin
				load_digits = {in_item.code_point[15:0], 16'h0000};
				load_count  = uks_pkg::CountW'(4);
			end
		end else begin
			load_digits = hex_aligned;
			load_count  = hex_count;
		end
	end

	always_comb begin
		case (host_mode_q)
			uks_pkg::MODE_LINUX:   first_state = uks_pkg::ST_PRE_DOWN;
			uks_pkg::MODE_MACOS:   first_state = uks_pkg::ST_DIG_DOWN;
			uks_pkg::MODE_WINDOWS: first_state = uks_pkg::ST_PRE_DOWN;
			default:               first_state = uks_pkg::ST_FINAL;
		endcase
	end

	assign sh_ctrl.load  = accept;
	assign sh_ctrl.shift = adv && (state_q == uks_pkg::ST_DIG_UP);

	uks_digit_shifter u_shifter (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (sh_ctrl),
		.load_digits (load_digits),
		.load_count  (load_count),
		.key         (dig_key),
		.last_digit  (last_digit)
	);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			uks_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = first_state;
				end
			end
			uks_pkg::ST_PRE_DOWN:  if (adv) state_nxt = uks_pkg::ST_PRE_UP;
			uks_pkg::ST_PRE_UP:    if (adv) state_nxt = uks_pkg::ST_DIG_DOWN;
			uks_pkg::ST_DIG_DOWN:  if (adv) state_nxt = uks_pkg::ST_DIG_UP;
			uks_pkg::ST_DIG_UP: begin
				if (adv) begin
					if (!last_digit) begin
						state_nxt = uks_pkg::ST_DIG_DOWN;
					end else if (host_mode_q == uks_pkg::MODE_LINUX) begin
						state_nxt = uks_pkg::ST_POST_DOWN;
					end else begin
						state_nxt = uks_pkg::ST_FINAL;
					end
				end
			end
			uks_pkg::ST_POST_DOWN: if (adv) state_nxt = uks_pkg::ST_POST_UP;
			uks_pkg::ST_POST_UP:   if (adv) state_nxt = uks_pkg::ST_IDLE;
			uks_pkg::ST_FINAL:     if (adv) state_nxt = uks_pkg::ST_IDLE;
			default:               state_nxt = uks_pkg::ST_IDLE;
		endcase
	end

	// Report for the current state.
	always_comb begin
		report.modifier_bits = uks_pkg::MOD_EMPTY;
		report.key_code      = uks_pkg::KEY_NONE;
		report.run_last      = 1'b0;
		report.bad_mode      = 1'b0;
		case (state_q)
			uks_pkg::ST_PRE_DOWN: begin
				if (host_mode_q == uks_pkg::MODE_LINUX) begin
					report.modifier_bits = uks_pkg::MOD_CTRL | uks_pkg::MOD_SHIFT;
					report.key_code      = uks_pkg::KEY_U;
				end else begin
					report.modifier_bits = uks_pkg::MOD_ALT;
					report.key_code      = uks_pkg::KEY_KP_PLUS;
				end
			end
			uks_pkg::ST_PRE_UP: begin
				if (host_mode_q != uks_pkg::MODE_LINUX) begin
					report.modifier_bits = uks_pkg::MOD_ALT;
				end
			end
			uks_pkg::ST_DIG_DOWN: begin
				if (host_mode_q != uks_pkg::MODE_LINUX) begin
					report.modifier_bits = uks_pkg::MOD_ALT;
				end
				report.key_code = dig_key;
			end
			uks_pkg::ST_DIG_UP: begin
				if (host_mode_q != uks_pkg::MODE_LINUX) begin
					report.modifier_bits = uks_pkg::MOD_ALT;
				end
			end
			uks_pkg::ST_POST_DOWN: report.key_code = uks_pkg::KEY_SPACE;
			uks_pkg::ST_POST_UP:   report.run_last = 1'b1;
			uks_pkg::ST_FINAL: begin
				report.run_last = 1'b1;
				report.bad_mode = (host_mode_q == uks_pkg::MODE_NONE);
			end
			default: ;
		endcase
		report.text_done = report.run_last & end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uks_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			end_q <= in_item.text_end;
		end
		if (adv) begin
			out_q <= report;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`UKS_ASSERT_IMP(a_bad_is_single, clk, arst_n, out_valid && out_item.bad_mode, out_item.run_last && out_item.key_code == uks_pkg::KEY_NONE)
	`UKS_ASSERT_IMP(a_last_releases, clk, arst_n, out_valid && out_item.run_last, out_item.key_code == uks_pkg::KEY_NONE)
	`UKS_ASSERT_NXT(a_last_ends_run, clk, arst_n, adv && report.run_last, state_q == uks_pkg::ST_IDLE)
	`UKS_ASSERT_IMP(a_done_on_last, clk, arst_n, out_valid && out_item.text_done, out_item.run_last)

endmodule

// ===== rtl/core/uks_digit_shifter.sv =====
// Nibble shift register that hands out hex digits most significant first,
// with a count of digits left. Depends on uks_pkg and the macro header.
`timescale 1ns / 1ps
`include "unicode_keystroke_sequencer_macros.svh"

module uks_digit_shifter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  uks_pkg::shift_ctrl_t         ctrl,
	input  logic [uks_pkg::DigitBits-1:0] load_digits,
	input  logic [uks_pkg::CountW-1:0]    load_count,
	output logic [7:0]                   key,
	output logic                         last_digit
);

	logic [uks_pkg::DigitBits-1:0] digits_q;
	logic [uks_pkg::CountW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= load_count;
		end else if (ctrl.shift) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Digits sit left aligned; each shift brings the next one to the top.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			digits_q <= load_digits;
		end else if (ctrl.shift) begin
			digits_q <= {digits_q[uks_pkg::DigitBits-5:0], 4'h0};
		end
	end

	assign key        = uks_pkg::digit_key(digits_q[uks_pkg::DigitBits-1 -: 4]);
	assign last_digit = (cnt_q == uks_pkg::CountW'(1));

	`UKS_ASSERT_IMP(a_shift_has_digit, clk, arst_n, ctrl.shift, cnt_q != '0)
	`UKS_ASSERT_IMP(a_no_shift_on_load, clk, arst_n, ctrl.load, !ctrl.shift)

endmodule

// ===== bench/tb_unicode_keystroke_sequencer.sv =====
// Self-checking testbench for unicode_keystroke_sequencer: predicts the HID
// report sequence of each code point for every host mode and checks each
// report transfer. Depends on uks_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_unicode_keystroke_sequencer;

	localparam int WatchdogLimit = 3000;
	localparam int SettleCycles  = 24;
	localparam int PressureHold  = 300;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_data;
	logic                in_valid;
	logic                in_stall;
	uks_pkg::in_item_t   in_item;
	logic                out_valid;
	logic                out_stall;
	uks_pkg::out_item_t  out_item;

	uks_pkg::out_item_t  expected_reports[$];
	uks_pkg::host_mode_t cur_mode;
	int                  fail_count;
	bit                  src_idle_en;
	bit                  sink_idle_en;
	int                  sink_hold_len;

	unicode_keystroke_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Report sequence predictor.

	function automatic logic [7:0] hex_usage(logic [3:0] d);
		if (d == 4'h0) begin
			return 8'h27;
		end else if (d < 4'hA) begin
			return 8'h1D + {4'h0, d};
		end else begin
			return 8'h04 + {4'h0, d - 4'hA};
		end
	endfunction

	function automatic int digit_total(logic [31:0] v);
		int w;
		w = 1;
		while (w < 8 && (v >> (4 * w)) != 0)
			w++;
		return w;
	endfunction

	function automatic void add_report(logic [7:0] mods, logic [7:0] key);
		uks_pkg::out_item_t r;
		r = '0;
		r.modifier_bits = mods;
		r.key_code = key;
		expected_reports.push_back(r);
	endfunction

	function automatic void add_tap(logic [7:0] down, logic [7:0] up, logic [7:0] key);
		add_report(down, key);
		add_report(up, uks_pkg::KEY_NONE);
	endfunction

	function automatic void add_hex(logic [7:0] mods, logic [31:0] v, int digits);
		for (int i = digits; i > 0; i--)
			add_tap(mods, mods, hex_usage(v[4 * (i - 1) +: 4]));
	endfunction

	function automatic void predict_reports(uks_pkg::host_mode_t mode,
			uks_pkg::in_item_t item);
		logic [31:0]        cp;
		logic [31:0]        v;
		logic [15:0]        hi;
		logic [15:0]        lo;
		uks_pkg::out_item_t last;
		cp = {11'b0, item.code_point};
		case (mode)
			uks_pkg::MODE_LINUX: begin
				add_tap(uks_pkg::MOD_CTRL | uks_pkg::MOD_SHIFT, uks_pkg::MOD_EMPTY,
					uks_pkg::KEY_U);
				add_hex(uks_pkg::MOD_EMPTY, cp, digit_total(cp));
				add_tap(uks_pkg::MOD_EMPTY, uks_pkg::MOD_EMPTY, uks_pkg::KEY_SPACE);
			end
			uks_pkg::MODE_MACOS: begin
				if (cp <= 32'hFFFF) begin
					add_hex(uks_pkg::MOD_ALT, cp, 4);
				end else begin
					// Supplementary planes go out as a UTF-16 surrogate pair.
					v = cp - {11'b0, uks_pkg::SURR_OFFSET};
					hi = uks_pkg::SURR_HIGH + v[25:10];
					lo = uks_pkg::SURR_LOW + {6'b0, v[9:0]};
					add_hex(uks_pkg::MOD_ALT, {16'b0, hi}, 4);
					add_hex(uks_pkg::MOD_ALT, {16'b0, lo}, 4);
				end
				add_report(uks_pkg::MOD_EMPTY, uks_pkg::KEY_NONE);
			end
			uks_pkg::MODE_WINDOWS: begin
				add_tap(uks_pkg::MOD_ALT, uks_pkg::MOD_ALT, uks_pkg::KEY_KP_PLUS);
				add_hex(uks_pkg::MOD_ALT, cp, digit_total(cp));
				add_report(uks_pkg::MOD_EMPTY, uks_pkg::KEY_NONE);
			end
			default: begin
				add_report(uks_pkg::MOD_EMPTY, uks_pkg::KEY_NONE);
			end
		endcase
		last = expected_reports.pop_back();
		last.run_last = 1'b1;
		last.bad_mode = (mode == uks_pkg::MODE_NONE);
		last.text_done = item.text_end;
		expected_reports.push_back(last);
	endfunction

	// Output side: stall generator and report checker.

	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_len > 0) begin
				hold = sink_hold_len;
				sink_hold_len = 0;
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	initial begin
		uks_pkg::out_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("report transfer with no expected report pending");
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("modifier_bits", want.modifier_bits, out_item.modifier_bits);
					check_field("key_code", want.key_code, out_item.key_code);
					check_field("run_last", want.run_last, out_item.run_last);
					check_field("bad_mode", want.bad_mode, out_item.bad_mode);
					check_field("text_done", want.text_done, out_item.text_done);
				end
			end
		end
	end

	// Ends the run when neither channel has moved for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Input side.

	task automatic send_item(logic [20:0] cp, logic te);
		uks_pkg::in_item_t item;
		int                gap;
		item.code_point = cp;
		item.text_end = te;
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_reports(cur_mode, item);
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_mode(uks_pkg::host_mode_t mode);
		drain_reports();
		cfg_we <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_mode = mode;
	endtask

	function automatic logic [20:0] pick_code_point();
		logic [31:0] r;
		int          k;
		case ($urandom_range(0, 5))
			0: r = $urandom_range(0, 255);
			1: r = $urandom_range(0, 32'hFFFF);
			2: r = $urandom_range(32'h10000, 32'h10FFFF);
			3: r = $urandom;
			4: begin
				// Values on either side of a hex digit boundary.
				k = $urandom_range(1, 5);
				r = 32'h1 << (4 * k);
				if ($urandom_range(0, 1) == 1)
					r = r - 1;
			end
			default: r = $urandom_range(32'hD800, 32'hDFFF);
		endcase
		return r[20:0];
	endfunction

	// Tests.

	// Runs in the mode left by reset, so no register write comes first.
	task automatic test_linux_directed();
		send_item(21'h0, 1'b0);
		send_item(21'hF, 1'b1);
		send_item(21'h10, 1'b0);
		send_item(21'h41, 1'b0);
		send_item(21'hFFFF, 1'b1);
		send_item(21'h10FFFF, 1'b0);
		send_item(21'h1FFFFF, 1'b1);
	endtask

	task automatic test_mode_directed();
		set_mode(uks_pkg::MODE_MACOS);
		send_item(21'h0, 1'b1);
		send_item(21'hFFFF, 1'b0);
		send_item(21'hD800, 1'b0);
		send_item(21'h10000, 1'b1);
		send_item(21'h10FFFF, 1'b0);
		send_item(21'h1FFFFF, 1'b1);
		set_mode(uks_pkg::MODE_WINDOWS);
		send_item(21'h0, 1'b0);
		send_item(21'hDFFF, 1'b1);
		send_item(21'h10FFFF, 1'b0);
		send_item(21'h1FFFFF, 1'b1);
		set_mode(uks_pkg::MODE_NONE);
		send_item(21'h0, 1'b0);
		send_item(21'h1FFFFF, 1'b1);
		send_item(21'h263A, 1'b0);
	endtask

	task automatic test_random_mix();
		uks_pkg::host_mode_t mode;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase < 4)
				mode = uks_pkg::host_mode_t'(phase);
			else
				mode = uks_pkg::host_mode_t'($urandom_range(0, 3));
			set_mode(mode);
			repeat (22)
				send_item(pick_code_point(), 1'($urandom_range(0, 1)));
		end
	endtask

	// The sink holds off long enough for the block to fill and stall its input.
	task automatic test_output_backpressure();
		set_mode(uks_pkg::MODE_LINUX);
		src_idle_en = 1'b0;
		sink_hold_len = PressureHold;
		repeat (10)
			send_item(pick_code_point(), 1'($urandom_range(0, 1)));
		drain_reports();
		src_idle_en = 1'b1;
	endtask

	task automatic test_closing_burst();
		set_mode(uks_pkg::MODE_WINDOWS);
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		repeat (8)
			send_item(pick_code_point(), 1'($urandom_range(0, 1)));
		set_mode(uks_pkg::MODE_MACOS);
		repeat (8)
			send_item(pick_code_point(), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = uks_pkg::MODE_LINUX;
		in_valid = 1'b0;
		in_item = '0;
		cur_mode = uks_pkg::MODE_LINUX;
		fail_count = 0;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		sink_hold_len = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_linux_directed();
		test_mode_directed();
		test_random_mix();
		test_output_backpressure();
		test_closing_burst();
		drain_reports();

		if (fail_count == 0 && expected_reports.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/uks_pkg.sv
rtl/core/uks_digit_shifter.sv
rtl/core/unicode_keystroke_sequencer.sv
bench/tb_unicode_keystroke_sequencer.sv
